// ===== rtl/cvr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the channel variance ranker.
// No dependencies.
package cvr_pkg;

    localparam int MaxCh     = 1024;
    localparam int EdgeDepth = MaxCh + 1;
    localparam int ChW       = 11;
    localparam int IdxW      = 10;
    localparam int RowW      = 8;
    localparam int RowCntW   = 9;
    localparam int SampleW   = 24;
    localparam int EdgeW     = 20;
    localparam int RankW     = 10;
    localparam int SumW      = 32;
    localparam int SqW       = 56;
    localparam int ScoreW    = 64;
    localparam int InDataW   = 80;
    localparam int OutDataW  = 80;
    localparam int AddrW     = 4;

    localparam logic [ScoreW-1:0] SCORE_MAX    = {1'b0, {(ScoreW-1){1'b1}}};
    localparam logic [ScoreW-1:0] SCORE_MASKED = {ScoreW{1'b1}};

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        CMD_EDGE    = 2'd0,
        CMD_SAMPLE  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_CH_COUNT  = 2'd0,
        REG_ROW_COUNT = 2'd1,
        REG_MASK_LOW  = 2'd2,
        REG_MASK_HIGH = 2'd3
    } t_reg;

    typedef struct packed {
        logic [ChW-1:0]     channel_count;
        logic [RowCntW-1:0] row_count;
        logic [EdgeW-1:0]   mask_low;
        logic [EdgeW-1:0]   mask_high;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LD_WR,
        S_SC_E0W,
        S_SC_RD,
        S_SC_MUL,
        S_SC_WR,
        S_RK_LD,
        S_RK_KEY,
        S_RK_SCAN,
        S_RK_WR,
        S_RD_1,
        S_RD_2,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/cvr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cvr_cfg.sv =====
`timescale 1ns / 1ps
// APB configuration registers of the channel variance ranker.
// Depends on cvr_pkg.
module cvr_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [cvr_pkg::AddrW-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cvr_pkg::t_cfg         o_cfg
);
    import cvr_pkg::*;

    t_cfg r_cfg;
    t_reg idx;

    assign idx    = t_reg'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= ChW'(1024);
            r_cfg.row_count     <= RowCntW'(256);
            r_cfg.mask_low      <= EdgeW'(88320);
            r_cfg.mask_high     <= EdgeW'(105600);
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_CH_COUNT:  r_cfg.channel_count <= pwdata[ChW-1:0];
                REG_ROW_COUNT: r_cfg.row_count     <= pwdata[RowCntW-1:0];
                REG_MASK_LOW:  r_cfg.mask_low      <= pwdata[EdgeW-1:0];
                REG_MASK_HIGH: r_cfg.mask_high     <= pwdata[EdgeW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CH_COUNT:  prdata = 32'(r_cfg.channel_count);
            REG_ROW_COUNT: prdata = 32'(r_cfg.row_count);
            REG_MASK_LOW:  prdata = 32'(r_cfg.mask_low);
            REG_MASK_HIGH: prdata = 32'(r_cfg.mask_high);
            default:       prdata = '0;
        endcase
    end
endmodule

// ===== rtl/cvr_score.sv =====
`timescale 1ns / 1ps
// Score unit: registered products rows*sumsq and sum^2, then subtract,
// clamp and mask. Depends on cvr_pkg.
module cvr_score (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  cvr_pkg::t_cfg             i_cfg,
    input  logic [cvr_pkg::SqW-1:0]   i_sq,
    input  logic [cvr_pkg::SumW-1:0]  i_sum,
    input  logic [cvr_pkg::EdgeW-1:0] i_edge_lo,
    input  logic [cvr_pkg::EdgeW-1:0] i_edge_hi,
    output logic [cvr_pkg::ScoreW-1:0] o_score
);
    import cvr_pkg::*;

    logic [SqW+RowCntW-1:0] r_prod;
    logic [2*SumW-1:0]      r_s2;
    logic                   r_masked;
    logic [SumW-1:0]        mag;
    logic [EdgeW:0]         mid2;
    logic [EdgeW:0]         lo2;
    logic [EdgeW:0]         hi2;
    logic [SqW+RowCntW-1:0] diff;

    always_comb begin
        mag  = i_sum[SumW-1] ? (~i_sum + SumW'(1)) : i_sum;
        mid2 = {1'b0, i_edge_lo} + {1'b0, i_edge_hi};
        lo2  = {i_cfg.mask_low, 1'b0};
        hi2  = {i_cfg.mask_high, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= i_sq * i_cfg.row_count;
            r_s2     <= mag * mag;
            r_masked <= (mid2 >= lo2) && (mid2 < hi2);
        end
    end

    always_comb begin
        diff = r_prod - (SqW+RowCntW)'(r_s2);
        if (r_masked) begin
            o_score = SCORE_MASKED;
        end else if (r_prod < (SqW+RowCntW)'(r_s2)) begin
            o_score = '0;
        end else if (diff[SqW+RowCntW-1:ScoreW-1] != '0) begin
            o_score = SCORE_MAX;
        end else begin
            o_score = diff[ScoreW-1:0];
        end
    end
endmodule

// ===== rtl/channel_variance_ranker.sv =====
`timescale 1ns / 1ps
// Channel variance ranker top level: command FSM and state memories.
// Depends on cvr_pkg, cvr_ram, cvr_cfg, cvr_score.
//
// Usage: commands enter on the s-side stream (tuser = command). An edge load
// writes the edge memory; a sample load is a read-modify-write of the
// per-channel sums. A compute scores each channel (read, multiply, write),
// then ranks every channel by counting the scores that beat it (higher when
// signed, or equal at a lower channel index), one score memory read per
// cycle, then emits one result item of kind 0.
// A rank read returns one item of kind 1.
// After reset the block clears the sum memories with s_tready low;
// configuration writes are taken meanwhile.
// A result waits in the output register while the receiver stalls; loads
// keep being accepted, and a further result waits until it drains.
// The APB port holds channel_count, row_count and the masked energy band.
module channel_variance_ranker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // channel[10:0], row[18:11], sample_value[42:19], energy_edge[62:43],
    // rank[72:63]
    input  logic [cvr_pkg::InDataW-1:0]     i_s_tdata,
    // cmd[1:0]
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // ranked_channel[9:0], channel_score[73:10], in_masked_band[74]
    output logic [cvr_pkg::OutDataW-1:0]    o_m_tdata,
    // result_kind[0]
    output logic                            o_m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cvr_pkg::AddrW-1:0]       paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cvr_pkg::*;

    t_cfg   cfg;
    t_state r_state, n_state;

    logic [ChW-1:0]    r_i, n_i, r_j, n_j, r_n, n_n, r_ranked, n_ranked;
    logic [IdxW-1:0]   r_jd, n_jd, r_cnt, n_cnt, r_clr, n_clr, r_ch, n_ch;
    logic              r_dv, n_dv;
    logic [ScoreW-1:0] r_key, n_key;
    logic [EdgeW-1:0]  r_eprev, n_eprev;
    logic [SumW-1:0]   r_v, n_v;
    logic [2*SampleW-1:0] r_sq, n_sq;
    logic              r_pkind, n_pkind, r_pmask, n_pmask;
    logic [IdxW-1:0]   r_pch, n_pch;
    logic [ScoreW-1:0] r_pscore, n_pscore;
    logic              r_ovalid, n_ovalid, r_okind, n_okind, r_omask, n_omask;
    logic [IdxW-1:0]   r_och, n_och;
    logic [ScoreW-1:0] r_oscore, n_oscore;

    logic accept;
    t_cmd in_cmd;
    logic [ChW-1:0]     in_ch;
    logic [RowW-1:0]    in_row;
    logic [SampleW-1:0] in_smp;
    logic [EdgeW-1:0]   in_edge;
    logic [RankW-1:0]   in_rank;
    logic [ChW-1:0]     eff_n;
    logic [SampleW-1:0] smag;
    logic               beats;

    logic sum_we, sum_re, sq_we, sq_re, edge_we, edge_re;
    logic score_we, score_re, rank_we, rank_re;
    logic [IdxW-1:0] sum_waddr, sum_raddr, score_waddr, score_raddr;
    logic [IdxW-1:0] rank_waddr, rank_raddr;
    logic [ChW-1:0]  edge_waddr, edge_raddr;
    logic [SumW-1:0] sum_wdata, sum_rdata;
    logic [SqW-1:0]  sq_wdata, sq_rdata;
    logic [EdgeW-1:0] edge_rdata;
    logic [ScoreW-1:0] score_rdata, unit_score;
    logic [IdxW-1:0] rank_rdata;
    logic            unit_en;

    cvr_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    cvr_ram #(.WIDTH(SumW), .DEPTH(MaxCh)) u_sum (
        .i_clk(i_clk), .i_we(sum_we), .i_waddr(sum_waddr), .i_wdata(sum_wdata),
        .i_re(sum_re), .i_raddr(sum_raddr), .o_rdata(sum_rdata)
    );

    cvr_ram #(.WIDTH(SqW), .DEPTH(MaxCh)) u_sq (
        .i_clk(i_clk), .i_we(sq_we), .i_waddr(sum_waddr), .i_wdata(sq_wdata),
        .i_re(sq_re), .i_raddr(sum_raddr), .o_rdata(sq_rdata)
    );

    cvr_ram #(.WIDTH(EdgeW), .DEPTH(EdgeDepth)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(in_edge),
        .i_re(edge_re), .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    cvr_ram #(.WIDTH(ScoreW), .DEPTH(MaxCh)) u_score (
        .i_clk(i_clk), .i_we(score_we), .i_waddr(score_waddr),
        .i_wdata(unit_score), .i_re(score_re), .i_raddr(score_raddr),
        .o_rdata(score_rdata)
    );

    cvr_ram #(.WIDTH(IdxW), .DEPTH(MaxCh)) u_rank (
        .i_clk(i_clk), .i_we(rank_we), .i_waddr(rank_waddr),
        .i_wdata(r_i[IdxW-1:0]), .i_re(rank_re), .i_raddr(rank_raddr),
        .o_rdata(rank_rdata)
    );

    cvr_score u_unit (
        .i_clk(i_clk), .i_en(unit_en), .i_cfg(cfg), .i_sq(sq_rdata),
        .i_sum(sum_rdata), .i_edge_lo(r_eprev), .i_edge_hi(edge_rdata),
        .o_score(unit_score)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_cmd     = t_cmd'(i_s_tuser);
    assign in_ch      = i_s_tdata[10:0];
    assign in_row     = i_s_tdata[18:11];
    assign in_smp     = i_s_tdata[42:19];
    assign in_edge    = i_s_tdata[62:43];
    assign in_rank    = i_s_tdata[72:63];
    assign eff_n      = (cfg.channel_count > ChW'(MaxCh)) ? ChW'(MaxCh)
                                                          : cfg.channel_count;
    assign smag       = in_smp[SampleW-1] ? (~in_smp + SampleW'(1)) : in_smp;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tdata  = {5'b0, r_omask, r_oscore, r_och};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ranked <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ranked <= n_ranked;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_n      <= n_n;
        r_jd     <= n_jd;
        r_cnt    <= n_cnt;
        r_ch     <= n_ch;
        r_dv     <= n_dv;
        r_key    <= n_key;
        r_eprev  <= n_eprev;
        r_v      <= n_v;
        r_sq     <= n_sq;
        r_pkind  <= n_pkind;
        r_pmask  <= n_pmask;
        r_pch    <= n_pch;
        r_pscore <= n_pscore;
        r_okind  <= n_okind;
        r_omask  <= n_omask;
        r_och    <= n_och;
        r_oscore <= n_oscore;
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_n      = r_n;
        n_jd     = r_jd;
        n_cnt    = r_cnt;
        n_clr    = r_clr;
        n_ch     = r_ch;
        n_dv     = r_dv;
        n_key    = r_key;
        n_eprev  = r_eprev;
        n_v      = r_v;
        n_sq     = r_sq;
        n_ranked = r_ranked;
        n_pkind  = r_pkind;
        n_pmask  = r_pmask;
        n_pch    = r_pch;
        n_pscore = r_pscore;
        n_ovalid = r_ovalid && !i_m_tready;
        n_okind  = r_okind;
        n_omask  = r_omask;
        n_och    = r_och;
        n_oscore = r_oscore;

        sum_we      = 1'b0;
        sq_we       = 1'b0;
        sum_re      = 1'b0;
        sq_re       = 1'b0;
        sum_waddr   = r_ch;
        sum_raddr   = r_i[IdxW-1:0];
        sum_wdata   = sum_rdata + r_v;
        sq_wdata    = sq_rdata + SqW'(r_sq);
        edge_we     = 1'b0;
        edge_re     = 1'b0;
        edge_waddr  = in_ch;
        edge_raddr  = r_i + ChW'(1);
        score_we    = 1'b0;
        score_re    = 1'b0;
        score_waddr = r_i[IdxW-1:0];
        score_raddr = r_i[IdxW-1:0];
        rank_we     = 1'b0;
        rank_re     = 1'b0;
        rank_waddr  = r_cnt;
        rank_raddr  = in_rank;
        unit_en     = 1'b0;
        beats       = 1'b0;

        case (r_state)
            S_CLR: begin
                sum_we    = 1'b1;
                sq_we     = 1'b1;
                sum_waddr = r_clr;
                sum_wdata = '0;
                sq_wdata  = '0;
                n_clr     = r_clr + IdxW'(1);
                if (r_clr == {IdxW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_EDGE: begin
                            edge_we = (in_ch <= ChW'(MaxCh));
                        end
                        CMD_SAMPLE: begin
                            if (in_ch < eff_n && {1'b0, in_row} < cfg.row_count) begin
                                sum_re    = 1'b1;
                                sq_re     = 1'b1;
                                sum_raddr = in_ch[IdxW-1:0];
                                n_ch      = in_ch[IdxW-1:0];
                                n_v       = SumW'($signed(in_smp));
                                n_sq      = smag * smag;
                                n_state   = S_LD_WR;
                            end
                        end
                        CMD_COMPUTE: begin
                            n_n = eff_n;
                            n_i = '0;
                            if (eff_n == '0) begin
                                n_ranked = '0;
                                n_pkind  = KIND_DONE;
                                n_pch    = '0;
                                n_pscore = '0;
                                n_pmask  = 1'b0;
                                n_state  = S_EMIT;
                            end else begin
                                edge_re    = 1'b1;
                                edge_raddr = '0;
                                n_state    = S_SC_E0W;
                            end
                        end
                        CMD_READ: begin
                            if ({1'b0, in_rank} < r_ranked) begin
                                rank_re = 1'b1;
                                n_state = S_RD_1;
                            end else begin
                                n_pkind  = KIND_READ;
                                n_pch    = '0;
                                n_pscore = '0;
                                n_pmask  = 1'b0;
                                n_state  = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LD_WR: begin
                sum_we  = 1'b1;
                sq_we   = 1'b1;
                n_state = S_IDLE;
            end
            S_SC_E0W: begin
                n_eprev = edge_rdata;
                n_state = S_SC_RD;
            end
            S_SC_RD: begin
                edge_re = 1'b1;
                sum_re  = 1'b1;
                sq_re   = 1'b1;
                n_state = S_SC_MUL;
            end
            S_SC_MUL: begin
                unit_en = 1'b1;
                n_eprev = edge_rdata;
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                score_we = 1'b1;
                n_i      = r_i + ChW'(1);
                if (r_i + ChW'(1) == r_n) begin
                    n_i     = '0;
                    n_state = S_RK_LD;
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_RK_LD: begin
                score_re = 1'b1;
                n_state  = S_RK_KEY;
            end
            S_RK_KEY: begin
                n_key   = score_rdata;
                n_j     = '0;
                n_dv    = 1'b0;
                n_cnt   = '0;
                n_state = S_RK_SCAN;
            end
            S_RK_SCAN: begin
                score_raddr = r_j[IdxW-1:0];
                score_re    = (r_j < r_n);
                n_dv        = (r_j < r_n);
                n_jd        = r_j[IdxW-1:0];
                if (r_j < r_n) begin
                    n_j = r_j + ChW'(1);
                end
                if (r_dv) begin
                    beats = ($signed(score_rdata) > $signed(r_key)) ||
                            (score_rdata == r_key && r_jd < r_i[IdxW-1:0]);
                    if (beats) begin
                        n_cnt = r_cnt + IdxW'(1);
                    end
                    if ({1'b0, r_jd} == r_n - ChW'(1)) begin
                        n_state = S_RK_WR;
                    end
                end
            end
            S_RK_WR: begin
                rank_we = 1'b1;
                if (r_i + ChW'(1) == r_n) begin
                    n_ranked = r_n;
                    n_pkind  = KIND_DONE;
                    n_pch    = '0;
                    n_pscore = '0;
                    n_pmask  = 1'b0;
                    n_state  = S_EMIT;
                end else begin
                    n_i     = r_i + ChW'(1);
                    n_state = S_RK_LD;
                end
            end
            S_RD_1: begin
                score_re    = 1'b1;
                score_raddr = rank_rdata;
                n_pch       = rank_rdata;
                n_state     = S_RD_2;
            end
            S_RD_2: begin
                n_pkind  = KIND_READ;
                n_pscore = score_rdata;
                n_pmask  = (score_rdata == SCORE_MASKED);
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_pkind;
                    n_och    = r_pch;
                    n_oscore = r_pscore;
                    n_omask  = r_pmask;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
